>>> hdl/uuse_pkg.sv
// ----------------------------------------------------------------------------
// uuse_pkg
// Shared types, constants and helpers for the six-bit printable encoder.
// ----------------------------------------------------------------------------
package uuse_pkg;

    // Encoding constants
    localparam int unsigned GROUP_BITS  = 6;
    localparam int unsigned BYTE_BITS   = 8;
    localparam int unsigned CHAR_BITS   = 7;
    localparam int unsigned CHAR_OFFSET = 32;

    // Depth of the command queue between the front and back parts
    localparam int unsigned QDEPTH  = 2;
    localparam int unsigned QPTR_W  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int unsigned QCNT_W  = $clog2(QDEPTH + 1);

    // Number of bits held back between bytes (0, 2 or 4)
    typedef enum logic [1:0] {
        PEND_NONE = 2'd0,
        PEND_TWO  = 2'd1,
        PEND_FOUR = 2'd2
    } pend_cnt_t;

    // One input item
    typedef struct packed {
        logic [BYTE_BITS-1:0] data_byte;
        logic                 message_last;
    } in_item_t;

    // One result item
    typedef struct packed {
        logic [CHAR_BITS-1:0] out_char;
        logic                 item_last;
        logic                 message_end;
    } out_item_t;

    // Classified byte: one or two groups to emit
    typedef struct packed {
        logic [GROUP_BITS-1:0] grp0;
        logic [GROUP_BITS-1:0] grp1;
        logic                  two;
        logic                  msg_last;
    } cmd_t;

    // Queue status seen by the back part
    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } q_head_t;

    // Map a six-bit group to its printable character
    function automatic logic [CHAR_BITS-1:0] to_char(input logic [GROUP_BITS-1:0] grp);
        return {1'b0, grp} + CHAR_BITS'(CHAR_OFFSET);
    endfunction

endpackage

>>> hdl/uuse_style_six_bit_encoder_top.sv
// An accepted item is written into the command queue and then loaded into
// the output register, where its first character shows.
// The output register gives one character per cycle unless the receiver
// stalls it; a byte yields one character or two.
// Reset clears the held bits, the command queue and the output register.
// ----------------------------------------------------------------------------
// uu_style_six_bit_encoder_top
// Six-bit printable-character encoder: bytes in, characters (group + 32) out.
// ----------------------------------------------------------------------------
module uu_style_six_bit_encoder_top import uuse_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_item_t  in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_data
);

    logic    q_full;
    logic    push;
    cmd_t    push_cmd;
    logic    pop;
    q_head_t head;

    // Classification and leftover bits
    uuse_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .q_full   (q_full),
        .push     (push),
        .push_cmd (push_cmd)
    );

    // Command queue
    uuse_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .full     (q_full),
        .head     (head)
    );

    // Character emission
    uuse_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .pop       (pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

>>> hdl/uuse_front.sv
// ----------------------------------------------------------------------------
// uuse_front
// Accepts bytes, splits the bit stream into six-bit groups and keeps the
// leftover bits between bytes.
// ----------------------------------------------------------------------------
module uuse_front import uuse_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  in_item_t in_data,
    input  logic     q_full,
    output logic     push,
    output cmd_t     push_cmd
);

    pend_cnt_t  pend_cnt_reg, pend_cnt_next;
    logic [3:0] pend_bits_reg, pend_bits_next;
    logic [7:0] byte_in;
    logic       last_in;

    assign in_ready = !q_full;
    assign push     = in_valid && in_ready;
    assign byte_in  = in_data.data_byte;
    assign last_in  = in_data.message_last;

    // Classify the byte against the bits already held
    always_comb
    begin
        push_cmd          = '0;
        push_cmd.msg_last = last_in;
        pend_cnt_next     = pend_cnt_reg;
        pend_bits_next    = pend_bits_reg;
        unique case (pend_cnt_reg)
            PEND_NONE:
            begin
                push_cmd.grp0  = byte_in[7:2];
                push_cmd.grp1  = {byte_in[1:0], 4'b0000};
                push_cmd.two   = last_in;
                pend_cnt_next  = PEND_TWO;
                pend_bits_next = {2'b00, byte_in[1:0]};
            end
            PEND_TWO:
            begin
                push_cmd.grp0  = {pend_bits_reg[1:0], byte_in[7:4]};
                push_cmd.grp1  = {byte_in[3:0], 2'b00};
                push_cmd.two   = last_in;
                pend_cnt_next  = PEND_FOUR;
                pend_bits_next = byte_in[3:0];
            end
            default:
            begin
                // Four bits pending: the byte completes two groups exactly.
                push_cmd.grp0  = {pend_bits_reg, byte_in[7:6]};
                push_cmd.grp1  = byte_in[5:0];
                push_cmd.two   = 1'b1;
                pend_cnt_next  = PEND_NONE;
                pend_bits_next = 4'b0000;
            end
        endcase
        // The message end leaves nothing pending; leftover bits went out zero-padded.
        if (last_in)
        begin
            pend_cnt_next  = PEND_NONE;
            pend_bits_next = 4'b0000;
        end
    end

    // Leftover state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_cnt_reg  <= PEND_NONE;
            pend_bits_reg <= 4'b0000;
        end
        else if (push)
        begin
            pend_cnt_reg  <= pend_cnt_next;
            pend_bits_reg <= pend_bits_next;
        end
    end

    // The unused pending code never appears.
    a_pend_code: assert property (@(posedge clk) disable iff (!rst_n)
        pend_cnt_reg == PEND_NONE || pend_cnt_reg == PEND_TWO || pend_cnt_reg == PEND_FOUR)
        else $error("front: invalid pending count");

    // A message end leaves nothing pending.
    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        push && in_data.message_last |=> pend_cnt_reg == PEND_NONE)
        else $error("front: bits pending after message end");

endmodule

>>> hdl/uuse_queue.sv
// ----------------------------------------------------------------------------
// uuse_queue
// Short command queue that decouples the front part from the back part.
// ----------------------------------------------------------------------------
module uuse_queue import uuse_pkg::*; (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  cmd_t    push_cmd,
    input  logic    pop,
    output logic    full,
    output q_head_t head
);

    cmd_t              mem [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    assign full       = (count_reg == QCNT_W'(QDEPTH));
    assign head.valid = (count_reg != '0);
    assign head.cmd   = mem[rd_ptr_reg];

    // Pointer and fill count updates
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

    // Never written when full, never read when empty.
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full || pop)
        else $error("queue: push while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head.valid)
        else $error("queue: pop while empty");

endmodule

>>> hdl/uuse_back.sv
// ----------------------------------------------------------------------------
// uuse_back
// Turns queued commands into characters, one per cycle unless the receiver
// stalls, through an output register.
// ----------------------------------------------------------------------------
module uuse_back import uuse_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  q_head_t   head,
    output logic      pop,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_data
);

    logic                  out_valid_reg, out_valid_next;
    out_item_t             out_data_reg, out_data_next;
    logic                  pend_reg, pend_next;
    logic [GROUP_BITS-1:0] pend_grp_reg, pend_grp_next;
    logic                  pend_msg_reg, pend_msg_next;
    logic                  load;

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // The output register may take a new item when empty or being drained.
    assign load = !out_valid_reg || out_ready;
    assign pop  = load && !pend_reg && head.valid;

    // Pick the second character of a pair first, else the next command
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        pend_next      = pend_reg;
        pend_grp_next  = pend_grp_reg;
        pend_msg_next  = pend_msg_reg;
        if (load)
        begin
            if (pend_reg)
            begin
                out_valid_next            = 1'b1;
                out_data_next.out_char    = to_char(pend_grp_reg);
                out_data_next.item_last   = 1'b1;
                out_data_next.message_end = pend_msg_reg;
                pend_next                 = 1'b0;
            end
            else if (head.valid)
            begin
                out_valid_next            = 1'b1;
                out_data_next.out_char    = to_char(head.cmd.grp0);
                out_data_next.item_last   = !head.cmd.two;
                out_data_next.message_end = !head.cmd.two && head.cmd.msg_last;
                pend_next                 = head.cmd.two;
                pend_grp_next             = head.cmd.grp1;
                pend_msg_next             = head.cmd.msg_last;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            pend_reg      <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            pend_reg      <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        pend_grp_reg <= pend_grp_next;
        pend_msg_reg <= pend_msg_next;
    end

    // A held second character always follows a first one still in view.
    a_pend_has_first: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> out_valid_reg && !out_data_reg.item_last)
        else $error("back: second character pending without first");

endmodule

>>> test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the six-bit printable-character encoder.
// A driver sends message bytes under valid/ready with random gaps, a monitor
// takes the characters with random stalls and one long hold-off, and every
// character is compared field by field with an in-bench encoder.
// ----------------------------------------------------------------------------
module tb import uuse_pkg::*; ();

    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned DRAIN_CYCLES = 12;
    localparam int unsigned RANDOM_BYTES = 800;
    localparam int unsigned HOLD_AT_CHAR = 500;
    localparam int unsigned HOLD_CYCLES = 300;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_ready;
    in_item_t  in_data = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    out_item_t out_data;

    // Bytes waiting to be sent and characters waiting to come back
    in_item_t  byte_queue[$];
    out_item_t char_queue[$];

    // Encoder state kept by the bench
    logic [3:0]  held_bits = '0;
    int unsigned held_count = 0;

    int unsigned bytes_total = 0;
    int unsigned bytes_taken = 0;
    int unsigned messages_done = 0;
    int unsigned double_bytes = 0;
    int unsigned chars_checked = 0;
    int unsigned mismatches = 0;
    int unsigned cycle_count = 0;

    uu_style_six_bit_encoder_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Mostly no gap, often a short one, now and then a long one.
    function automatic int unsigned idle_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    // Append one byte to the send queue.
    function automatic void queue_byte(input in_item_t item);
        byte_queue = {byte_queue, item};
    endfunction

    // Regroup one byte with the held bits into characters and queue them.
    function automatic void encode_byte(input in_item_t item);
        logic [11:0] acc;
        logic [5:0]  grp [2];
        int unsigned total;
        int          n;
        out_item_t   ch;

        acc = ((12'(held_bits) & ((12'd1 << held_count) - 12'd1)) << BYTE_BITS)
              | 12'(item.data_byte);
        total = held_count + BYTE_BITS;
        n = 0;
        while (total >= GROUP_BITS && n < 2)
        begin
            total = total - GROUP_BITS;
            grp[n] = 6'(acc >> total);
            n++;
        end
        acc = acc & ((12'd1 << total) - 12'd1);

        // A message tail that does not fill a group is padded with zeros.
        if (item.message_last && total > 0 && n < 2)
        begin
            grp[n] = 6'(acc << (GROUP_BITS - total));
            n++;
            total = 0;
            acc = '0;
        end

        if (item.message_last)
        begin
            held_bits = '0;
            held_count = 0;
            messages_done++;
        end
        else
        begin
            held_bits = acc[3:0];
            held_count = total;
        end

        if (n == 2)
            double_bytes++;
        for (int k = 0; k < n; k++)
        begin
            ch.out_char = {1'b0, grp[k]} + 7'(CHAR_OFFSET);
            ch.item_last = (k == n - 1);
            ch.message_end = (k == n - 1) && item.message_last;
            char_queue = {char_queue, ch};
        end
    endfunction

    // Driver: offers bytes from the queue, waiting a random gap after each.
    always @(posedge clk or negedge rst_n)
    begin : driver
        int unsigned tx_wait;
        int unsigned tx_calm;
        logic        offering;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data <= '0;
            tx_wait = 0;
            tx_calm = 0;
        end
        else
        begin
            offering = in_valid;
            if (in_valid && in_ready)
            begin
                encode_byte(in_data);
                bytes_taken++;
                offering = 1'b0;
            end

            if (!offering)
            begin
                if (tx_wait != 0)
                begin
                    tx_wait = tx_wait - 1;
                    in_valid <= 1'b0;
                end
                else if (byte_queue.size() != 0)
                begin
                    in_data <= byte_queue.pop_front();
                    in_valid <= 1'b1;
                    // Occasional stretches with back-to-back bytes.
                    if (tx_calm != 0)
                        tx_calm = tx_calm - 1;
                    else if ($urandom_range(0, 49) == 0)
                        tx_calm = $urandom_range(20, 60);
                    tx_wait = (tx_calm != 0) ? 0 : idle_len();
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each character and stalls at random after taking one.
    always @(posedge clk or negedge rst_n)
    begin : monitor
        int unsigned rx_hold;
        int unsigned rx_calm;
        int unsigned stall;
        bit          long_hold_done;
        out_item_t   want;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            rx_hold = 0;
            rx_calm = 0;
            long_hold_done = 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (char_queue.size() == 0)
                begin
                    $error("character %0h arrived with none expected", out_data.out_char);
                    mismatches++;
                end
                else
                begin
                    want = char_queue.pop_front();
                    if (out_data.out_char !== want.out_char)
                    begin
                        $error("out_char: expected %0h, got %0h",
                               want.out_char, out_data.out_char);
                        mismatches++;
                    end
                    if (out_data.item_last !== want.item_last)
                    begin
                        $error("item_last: expected %0b, got %0b",
                               want.item_last, out_data.item_last);
                        mismatches++;
                    end
                    if (out_data.message_end !== want.message_end)
                    begin
                        $error("message_end: expected %0b, got %0b",
                               want.message_end, out_data.message_end);
                        mismatches++;
                    end
                end
                chars_checked++;
            end

            if (rx_hold != 0)
            begin
                rx_hold = rx_hold - 1;
                out_ready <= (rx_hold == 0);
            end
            else if (out_valid && out_ready)
            begin
                // One long hold-off lets the encoder fill up and stall its input.
                if (!long_hold_done && chars_checked >= HOLD_AT_CHAR)
                begin
                    stall = HOLD_CYCLES;
                    long_hold_done = 1'b1;
                end
                else
                begin
                    if (rx_calm != 0)
                        rx_calm = rx_calm - 1;
                    else if ($urandom_range(0, 49) == 0)
                        rx_calm = $urandom_range(20, 60);
                    stall = (rx_calm != 0) ? 0 : idle_len();
                end
                rx_hold = stall;
                out_ready <= (stall == 0);
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial
    begin : stimulus
        in_item_t item;
        int unsigned msg_len;
        int unsigned sent;

        // Directed bytes: single-byte messages, an aligned three-byte tail,
        // all-zero and all-one data, and each held-bit count at the last byte.
        queue_byte('{data_byte: 8'h00, message_last: 1'b1});
        queue_byte('{data_byte: 8'hFF, message_last: 1'b1});
        queue_byte('{data_byte: 8'hFF, message_last: 1'b0});
        queue_byte('{data_byte: 8'hFF, message_last: 1'b0});
        queue_byte('{data_byte: 8'hFF, message_last: 1'b1});
        queue_byte('{data_byte: 8'h00, message_last: 1'b0});
        queue_byte('{data_byte: 8'h00, message_last: 1'b0});
        queue_byte('{data_byte: 8'h00, message_last: 1'b1});
        queue_byte('{data_byte: 8'h80, message_last: 1'b0});
        queue_byte('{data_byte: 8'h01, message_last: 1'b1});
        queue_byte('{data_byte: 8'hA5, message_last: 1'b0});
        queue_byte('{data_byte: 8'h5A, message_last: 1'b1});
        queue_byte('{data_byte: 8'hC3, message_last: 1'b0});
        queue_byte('{data_byte: 8'h3C, message_last: 1'b0});
        queue_byte('{data_byte: 8'h7E, message_last: 1'b0});
        queue_byte('{data_byte: 8'h81, message_last: 1'b1});
        queue_byte('{data_byte: 8'hFC, message_last: 1'b0});
        queue_byte('{data_byte: 8'h0F, message_last: 1'b1});

        // Random messages, mostly short, a few long.
        sent = 0;
        while (sent < RANDOM_BYTES)
        begin
            if ($urandom_range(0, 9) == 0)
                msg_len = $urandom_range(20, 60);
            else
                msg_len = $urandom_range(1, 8);
            for (int i = 0; i < msg_len; i++)
            begin
                item.data_byte = 8'($urandom());
                item.message_last = (i == msg_len - 1);
                queue_byte(item);
            end
            sent = sent + msg_len;
        end
        bytes_total = byte_queue.size();

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        while (bytes_taken != bytes_total || char_queue.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (char_queue.size() != 0)
        begin
            $error("%0d characters never arrived", char_queue.size());
            mismatches++;
        end

        $display("Sent %0d bytes in %0d messages; %0d of them gave two characters.",
                 bytes_taken, messages_done, double_bytes);
        $display("Checked %0d characters, including one long receiver hold-off.",
                 chars_checked);
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
